[rtl/sxt_pkg.sv]
// ----------------------------------------------------------------------------
// sxt_pkg
// Shared types, token codes and character classes for the s-expression
// tokenizer.
// ----------------------------------------------------------------------------
package sxt_pkg;

  localparam logic [2:0] KIND_PUNC = 3'd0;
  localparam logic [2:0] KIND_SYM  = 3'd1;
  localparam logic [2:0] KIND_NUM  = 3'd2;
  localparam logic [2:0] KIND_STR  = 3'd3;
  localparam logic [2:0] KIND_EOF  = 3'd4;
  localparam logic [2:0] KIND_ERR  = 3'd5;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_NUM  = 2'd1;
  localparam logic [1:0] ERR_OPEN_STR = 2'd2;

  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_BTICK   = 8'h60;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_N = 8'h6E;
  localparam logic [7:0] CH_LOWER_T = 8'h74;

  typedef struct packed {
    logic [2:0] token_kind;
    logic       has_char;
    logic [7:0] char_out;
    logic       token_start;
    logic       token_end;
    logic       raw_string;
    logic [1:0] error_code;
    logic       last_of_step;
  } tok_item_t;

  typedef struct packed {
    logic      two;
    tok_item_t first;
    tok_item_t second;
  } tok_entry_t;

  function automatic logic is_spacing(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
  endfunction

  function automatic logic is_punc(input logic [7:0] c);
    return (c == CH_DOT) || (c == CH_COLON) || (c == CH_BTICK) || (c == CH_COMMA) ||
           (c == CH_SEMI) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
           (c == CH_LBRACE) || (c == CH_RBRACE);
  endfunction

  function automatic logic is_numeral(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic tok_item_t make_item(input logic [2:0] kind, input logic has,
                                          input logic [7:0] ch, input logic start,
                                          input logic stop, input logic raw,
                                          input logic [1:0] err);
    tok_item_t it;
    it.token_kind   = kind;
    it.has_char     = has;
    it.char_out     = has ? ch : 8'd0;
    it.token_start  = start;
    it.token_end    = stop;
    it.raw_string   = raw;
    it.error_code   = err;
    it.last_of_step = 1'b0;
    return it;
  endfunction

endpackage

[rtl/sxt_if.sv]
// ----------------------------------------------------------------------------
// sxt_byte_if / sxt_token_if
// Valid/ready channels for source bytes and for token beats.
// ----------------------------------------------------------------------------
interface sxt_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface sxt_token_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic       has_char;
  logic [7:0] char_out;
  logic       token_start;
  logic       token_end;
  logic       raw_string;
  logic [1:0] error_code;
  logic       last_of_step;

  modport source (output valid, output token_kind, output has_char, output char_out,
                  output token_start, output token_end, output raw_string,
                  output error_code, output last_of_step, input ready);
  modport sink (input valid, input token_kind, input has_char, input char_out,
                input token_start, input token_end, input raw_string,
                input error_code, input last_of_step, output ready);
endinterface

[rtl/sxt_front.sv]
// ----------------------------------------------------------------------------
// sxt_front
// Accepts source bytes, runs the lexer state and turns each byte into at most
// one queue entry of one or two token beats.
// ----------------------------------------------------------------------------
module sxt_front
  import sxt_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  sxt_byte_if.sink     text,
  input  logic         q_ready,
  output logic         push,
  output tok_entry_t   push_entry
);

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_SYM  = 3'd1;
  localparam logic [2:0] MODE_NUM  = 3'd2;
  localparam logic [2:0] MODE_STR  = 3'd3;
  localparam logic [2:0] MODE_DEAD = 3'd4;

  logic [2:0] lex_mode;
  logic       single_quoted;
  logic       escape_pending;
  logic [2:0] lex_mode_next;
  logic       single_quoted_next;
  logic       escape_pending_next;
  logic [1:0] count;
  logic       accept;

  always_comb begin
    logic [7:0] c;
    logic       eof;
    logic       sep;
    logic       raw;
    logic [7:0] delim;
    logic       idle_has;
    tok_item_t  idle_item;
    logic [2:0] idle_mode;
    logic       idle_sq;
    logic       idle_esc;
    tok_item_t  first;
    tok_item_t  second;

    c     = text.in_byte;
    eof   = text.end_of_input;
    sep   = eof || is_spacing(c) || is_punc(c);
    raw   = single_quoted;
    delim = raw ? CH_SQUOTE : CH_DQUOTE;

    idle_has  = 1'b0;
    idle_item = '0;
    idle_mode = MODE_IDLE;
    idle_sq   = single_quoted;
    idle_esc  = escape_pending;
    if (eof) begin
      idle_has  = 1'b1;
      idle_item = make_item(KIND_EOF, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, ERR_NONE);
    end else if (is_spacing(c)) begin
      idle_has = 1'b0;
    end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
      idle_has  = 1'b1;
      idle_mode = MODE_STR;
      idle_sq   = (c == CH_SQUOTE);
      idle_esc  = 1'b0;
      idle_item = make_item(KIND_STR, 1'b0, 8'd0, 1'b1, 1'b0, c == CH_SQUOTE, ERR_NONE);
    end else if (is_numeral(c)) begin
      idle_has  = 1'b1;
      idle_mode = MODE_NUM;
      idle_item = make_item(KIND_NUM, 1'b1, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
    end else if (is_punc(c)) begin
      idle_has  = 1'b1;
      idle_item = make_item(KIND_PUNC, 1'b1, c, 1'b1, 1'b1, 1'b0, ERR_NONE);
    end else begin
      idle_has  = 1'b1;
      idle_mode = MODE_SYM;
      idle_item = make_item(KIND_SYM, 1'b1, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
    end

    first               = '0;
    second              = '0;
    count               = 2'd0;
    lex_mode_next       = lex_mode;
    single_quoted_next  = single_quoted;
    escape_pending_next = escape_pending;

    case (lex_mode)
      MODE_IDLE: begin
        first               = idle_item;
        count               = {1'b0, idle_has};
        lex_mode_next       = idle_mode;
        single_quoted_next  = idle_sq;
        escape_pending_next = idle_esc;
      end
      MODE_SYM, MODE_NUM: begin
        if (lex_mode == MODE_NUM && !eof && is_numeral(c)) begin
          first = make_item(KIND_NUM, 1'b1, c, 1'b0, 1'b0, 1'b0, ERR_NONE);
          count = 2'd1;
        end else if (sep) begin
          first = make_item((lex_mode == MODE_NUM) ? KIND_NUM : KIND_SYM, 1'b0, 8'd0,
                            1'b0, 1'b1, 1'b0, ERR_NONE);
          second              = idle_item;
          count               = idle_has ? 2'd2 : 2'd1;
          lex_mode_next       = idle_mode;
          single_quoted_next  = idle_sq;
          escape_pending_next = idle_esc;
        end else if (lex_mode == MODE_NUM) begin
          first         = make_item(KIND_ERR, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, ERR_BAD_NUM);
          count         = 2'd1;
          lex_mode_next = MODE_DEAD;
        end else begin
          first = make_item(KIND_SYM, 1'b1, c, 1'b0, 1'b0, 1'b0, ERR_NONE);
          count = 2'd1;
        end
      end
      MODE_STR: begin
        if (eof || c == CH_NEWLINE) begin
          first  = make_item(KIND_ERR, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, ERR_OPEN_STR);
          second = make_item(KIND_EOF, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, ERR_NONE);
          count  = eof ? 2'd2 : 2'd1;
          lex_mode_next       = MODE_IDLE;
          escape_pending_next = 1'b0;
          single_quoted_next  = 1'b0;
        end else if (c == delim) begin
          if (escape_pending) begin
            if (!raw) begin
              first  = make_item(KIND_STR, 1'b1, CH_BSLASH, 1'b0, 1'b0, raw, ERR_NONE);
              second = make_item(KIND_STR, 1'b1, c, 1'b0, 1'b0, raw, ERR_NONE);
              count  = 2'd2;
            end else begin
              first = make_item(KIND_STR, 1'b1, c, 1'b0, 1'b0, raw, ERR_NONE);
              count = 2'd1;
            end
            escape_pending_next = 1'b0;
          end else begin
            first              = make_item(KIND_STR, 1'b0, 8'd0, 1'b0, 1'b1, raw, ERR_NONE);
            count              = 2'd1;
            lex_mode_next      = MODE_IDLE;
            single_quoted_next = 1'b0;
          end
        end else if (c == CH_BSLASH) begin
          if (raw) begin
            first               = make_item(KIND_STR, 1'b1, c, 1'b0, 1'b0, raw, ERR_NONE);
            count               = 2'd1;
            escape_pending_next = !escape_pending;
          end else if (escape_pending) begin
            first = make_item(KIND_STR, 1'b1, CH_BSLASH, 1'b0, 1'b0, raw, ERR_NONE);
            count = 2'd1;
            escape_pending_next = 1'b0;
          end else begin
            escape_pending_next = 1'b1;
          end
        end else begin
          if (!raw && escape_pending) begin
            if (c == CH_LOWER_N) begin
              first = make_item(KIND_STR, 1'b1, CH_NEWLINE, 1'b0, 1'b0, raw, ERR_NONE);
              count = 2'd1;
            end else if (c == CH_LOWER_T) begin
              first = make_item(KIND_STR, 1'b1, CH_TAB, 1'b0, 1'b0, raw, ERR_NONE);
              count = 2'd1;
            end else begin
              first  = make_item(KIND_STR, 1'b1, CH_BSLASH, 1'b0, 1'b0, raw, ERR_NONE);
              second = make_item(KIND_STR, 1'b1, c, 1'b0, 1'b0, raw, ERR_NONE);
              count  = 2'd2;
            end
          end else begin
            first = make_item(KIND_STR, 1'b1, c, 1'b0, 1'b0, raw, ERR_NONE);
            count = 2'd1;
          end
          escape_pending_next = 1'b0;
        end
      end
      default: begin
        lex_mode_next = MODE_DEAD;
      end
    endcase

    if (count == 2'd2) begin
      second.last_of_step = 1'b1;
    end else begin
      first.last_of_step = 1'b1;
    end

    push_entry.two    = (count == 2'd2);
    push_entry.first  = first;
    push_entry.second = second;
  end

  assign text.ready = q_ready;
  assign accept     = text.valid && q_ready;
  assign push       = accept && (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      lex_mode       <= MODE_IDLE;
      single_quoted  <= 1'b0;
      escape_pending <= 1'b0;
    end else if (accept) begin
      lex_mode       <= lex_mode_next;
      single_quoted  <= single_quoted_next;
      escape_pending <= escape_pending_next;
    end
  end

endmodule

[rtl/sxt_queue.sv]
// ----------------------------------------------------------------------------
// sxt_queue
// Small first-in first-out store of token entries between the front and the
// back, so that each side stalls on its own.
// ----------------------------------------------------------------------------
module sxt_queue
  import sxt_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  tok_entry_t push_entry,
  output logic       push_ready,
  output logic       pop_valid,
  output tok_entry_t pop_entry,
  input  logic       pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  tok_entry_t       store [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_entry  = store[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("queue fill count beyond depth");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue did not grow on a lone push");
  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    do_pop && !do_push |=> count == $past(count) - 1'b1)
    else $error("queue did not shrink on a lone pop");
`endif

endmodule

[rtl/sxt_back.sv]
// ----------------------------------------------------------------------------
// sxt_back
// Drains queue entries and sends their beats one at a time through a
// registered output stage, holding the second beat of an entry aside.
// ----------------------------------------------------------------------------
module sxt_back
  import sxt_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tok_entry_t    q_entry,
  output logic          pop,
  sxt_token_if.source   tokens
);

  logic      out_valid;
  tok_item_t out_item;
  logic      held_valid;
  tok_item_t held_item;
  logic      stage_free;
  logic      load_first;
  logic      load_second;

  assign stage_free  = !out_valid || tokens.ready;
  assign load_second = held_valid && stage_free;
  assign load_first  = q_valid && !held_valid && stage_free;
  assign pop         = load_first;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      held_valid <= 1'b0;
    end else begin
      if (stage_free) begin
        out_valid <= held_valid || q_valid;
      end
      if (load_second) begin
        held_valid <= 1'b0;
      end else if (load_first) begin
        held_valid <= q_entry.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_second) begin
      out_item <= held_item;
    end else if (load_first) begin
      out_item <= q_entry.first;
    end
    if (load_first) begin
      held_item <= q_entry.second;
    end
  end

  assign tokens.valid        = out_valid;
  assign tokens.token_kind   = out_item.token_kind;
  assign tokens.has_char     = out_item.has_char;
  assign tokens.char_out     = out_item.char_out;
  assign tokens.token_start  = out_item.token_start;
  assign tokens.token_end    = out_item.token_end;
  assign tokens.raw_string   = out_item.raw_string;
  assign tokens.error_code   = out_item.error_code;
  assign tokens.last_of_step = out_item.last_of_step;

`ifndef SYNTHESIS
  a_held_not_last_pop: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> !pop) else $error("entry popped while a beat is held");
  a_held_is_last: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> held_item.last_of_step) else $error("held beat does not close its step");
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tokens.ready |=> out_valid && $stable(out_item))
    else $error("output beat changed under stall");
`endif

endmodule

[rtl/s_expression_tokenizer.sv]
// Path: an accepted byte's entry is written into the queue, then its first beat is
// loaded into the output register; a second beat waits aside until the first is taken.
// Throughput: one byte per cycle while each byte gives at most one beat and no
// token stall; a byte with two beats holds the single output register for both.
// Reset (synchronous, active high) returns the lexer to idle and empties the queue.
// ----------------------------------------------------------------------------
// s_expression_tokenizer
// Byte-at-a-time s-expression lexer: a classifying front end, an entry queue
// and a back end that sends token beats one per cycle while tokens.ready is high.
// ----------------------------------------------------------------------------
module s_expression_tokenizer
  import sxt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  sxt_byte_if.sink    text,
  sxt_token_if.source tokens
);

  logic       push;
  tok_entry_t push_entry;
  logic       q_ready;
  logic       q_valid;
  tok_entry_t q_entry;
  logic       pop;

  sxt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text       (text),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  sxt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (q_ready),
    .pop_valid  (q_valid),
    .pop_entry  (q_entry),
    .pop        (pop)
  );

  sxt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .pop     (pop),
    .tokens  (tokens)
  );

endmodule

[verif/tb_s_expression_tokenizer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_s_expression_tokenizer
// Self-checking bench for the s-expression tokenizer. Source text is driven a
// byte per beat from a queue, each accepted byte is run through a behavioural
// lexer to build the expected token beats, and every token beat taken from the
// block is compared field by field. The run covers directed corner cases,
// random well-formed text with some noise, four idling regimes, and finally a
// malformed number that leaves the lexer locked until reset.
// ----------------------------------------------------------------------------
module tb_s_expression_tokenizer;
  import sxt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 163;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_SYMBOL, SCAN_NUMBER, SCAN_STRING, SCAN_DEAD
  } scan_mode_t;

  typedef struct {
    logic [7:0] text_byte;
    logic       eoi;
    bit         wait_empty;
  } text_item_t;

  logic clk = 1'b0;
  logic rst;

  sxt_byte_if  text_bus ();
  sxt_token_if token_bus ();

  s_expression_tokenizer DUT (
    .clk    (clk),
    .rst    (rst),
    .text   (text_bus),
    .tokens (token_bus)
  );

  text_item_t  pending_text[$];
  tok_item_t   expected_beats[$];
  tok_item_t   step_beats[$];
  scan_mode_t  scan_mode    = SCAN_IDLE;
  logic        quote_single = 1'b0;
  logic        escape_armed = 1'b0;
  logic        byte_fire    = 1'b0;
  bit          hold_next    = 1'b0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_loaded   = 0;
  int unsigned bytes_taken    = 0;
  int unsigned phase_items    = 0;
  int unsigned mismatches     = 0;
  int unsigned cycle_count    = 0;

  logic [7:0] marks [9] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_BTICK,
                            CH_SEMI, CH_COLON, CH_COMMA, CH_DOT};

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE;
  endfunction

  function automatic bit is_mark(logic [7:0] c);
    bit hit;
    hit = 1'b0;
    foreach (marks[i]) if (marks[i] == c) hit = 1'b1;
    return hit;
  endfunction

  function automatic bit is_decimal(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic void add_beat(logic [2:0] kind, logic has, logic [7:0] ch,
                                   logic start, logic stop, logic raw,
                                   logic [1:0] err);
    tok_item_t b;
    b.token_kind   = kind;
    b.has_char     = has;
    b.char_out     = has ? ch : 8'd0;
    b.token_start  = start;
    b.token_end    = stop;
    b.raw_string   = raw;
    b.error_code   = err;
    b.last_of_step = 1'b0;
    step_beats.push_back(b);
  endfunction

  function automatic void open_token(logic [7:0] c, logic eoi);
    if (eoi) begin
      add_beat(KIND_EOF, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, ERR_NONE);
      scan_mode = SCAN_IDLE;
    end else if (is_blank(c)) begin
      scan_mode = SCAN_IDLE;
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      scan_mode    = SCAN_STRING;
      quote_single = (c == CH_SQUOTE);
      escape_armed = 1'b0;
      add_beat(KIND_STR, 1'b0, 8'd0, 1'b1, 1'b0, quote_single, ERR_NONE);
    end else if (is_decimal(c)) begin
      scan_mode = SCAN_NUMBER;
      add_beat(KIND_NUM, 1'b1, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
    end else if (is_mark(c)) begin
      scan_mode = SCAN_IDLE;
      add_beat(KIND_PUNC, 1'b1, c, 1'b1, 1'b1, 1'b0, ERR_NONE);
    end else begin
      scan_mode = SCAN_SYMBOL;
      add_beat(KIND_SYM, 1'b1, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
    end
  endfunction

  function automatic void string_byte(logic [7:0] c, logic eoi);
    logic       raw;
    logic [7:0] delim;
    raw   = quote_single;
    delim = raw ? CH_SQUOTE : CH_DQUOTE;
    if (eoi || c == CH_NEWLINE) begin
      add_beat(KIND_ERR, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, ERR_OPEN_STR);
      scan_mode    = SCAN_IDLE;
      escape_armed = 1'b0;
      quote_single = 1'b0;
      if (eoi) add_beat(KIND_EOF, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, ERR_NONE);
    end else if (c == delim) begin
      if (escape_armed) begin
        if (!raw) add_beat(KIND_STR, 1'b1, CH_BSLASH, 1'b0, 1'b0, raw, ERR_NONE);
        add_beat(KIND_STR, 1'b1, c, 1'b0, 1'b0, raw, ERR_NONE);
        escape_armed = 1'b0;
      end else begin
        add_beat(KIND_STR, 1'b0, 8'd0, 1'b0, 1'b1, raw, ERR_NONE);
        scan_mode    = SCAN_IDLE;
        quote_single = 1'b0;
      end
    end else if (c == CH_BSLASH) begin
      if (raw) begin
        add_beat(KIND_STR, 1'b1, c, 1'b0, 1'b0, raw, ERR_NONE);
        escape_armed = !escape_armed;
      end else if (escape_armed) begin
        add_beat(KIND_STR, 1'b1, CH_BSLASH, 1'b0, 1'b0, raw, ERR_NONE);
        escape_armed = 1'b0;
      end else begin
        escape_armed = 1'b1;
      end
    end else begin
      if (!raw && escape_armed) begin
        if (c == CH_LOWER_N) begin
          add_beat(KIND_STR, 1'b1, CH_NEWLINE, 1'b0, 1'b0, raw, ERR_NONE);
        end else if (c == CH_LOWER_T) begin
          add_beat(KIND_STR, 1'b1, CH_TAB, 1'b0, 1'b0, raw, ERR_NONE);
        end else begin
          add_beat(KIND_STR, 1'b1, CH_BSLASH, 1'b0, 1'b0, raw, ERR_NONE);
          add_beat(KIND_STR, 1'b1, c, 1'b0, 1'b0, raw, ERR_NONE);
        end
      end else begin
        add_beat(KIND_STR, 1'b1, c, 1'b0, 1'b0, raw, ERR_NONE);
      end
      escape_armed = 1'b0;
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic eoi);
    bit sep;
    sep = eoi || is_blank(c) || is_mark(c);
    case (scan_mode)
      SCAN_IDLE: begin
        open_token(c, eoi);
      end
      SCAN_SYMBOL: begin
        if (sep) begin
          add_beat(KIND_SYM, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
          open_token(c, eoi);
        end else begin
          add_beat(KIND_SYM, 1'b1, c, 1'b0, 1'b0, 1'b0, ERR_NONE);
        end
      end
      SCAN_NUMBER: begin
        if (!eoi && is_decimal(c)) begin
          add_beat(KIND_NUM, 1'b1, c, 1'b0, 1'b0, 1'b0, ERR_NONE);
        end else if (sep) begin
          add_beat(KIND_NUM, 1'b0, 8'd0, 1'b0, 1'b1, 1'b0, ERR_NONE);
          open_token(c, eoi);
        end else begin
          add_beat(KIND_ERR, 1'b0, 8'd0, 1'b1, 1'b1, 1'b0, ERR_BAD_NUM);
          scan_mode = SCAN_DEAD;
        end
      end
      SCAN_STRING: begin
        string_byte(c, eoi);
      end
      default: begin
        scan_mode = SCAN_DEAD;
      end
    endcase
    if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last_of_step = 1'b1;
    foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    step_beats.delete();
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_token_beat();
    tok_item_t got;
    tok_item_t want;
    got.token_kind   = token_bus.token_kind;
    got.has_char     = token_bus.has_char;
    got.char_out     = token_bus.char_out;
    got.token_start  = token_bus.token_start;
    got.token_end    = token_bus.token_end;
    got.raw_string   = token_bus.raw_string;
    got.error_code   = token_bus.error_code;
    got.last_of_step = token_bus.last_of_step;
    if (expected_beats.size() == 0) begin
      $display("%0t: token beat with none expected, expected nothing, got %h",
               $time, got);
      mismatches++;
    end else begin
      want = expected_beats.pop_front();
      compare_field("token_kind", 8'(want.token_kind), 8'(got.token_kind));
      compare_field("has_char", 8'(want.has_char), 8'(got.has_char));
      compare_field("char_out", want.char_out, got.char_out);
      compare_field("token_start", 8'(want.token_start), 8'(got.token_start));
      compare_field("token_end", 8'(want.token_end), 8'(got.token_end));
      compare_field("raw_string", 8'(want.raw_string), 8'(got.raw_string));
      compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
      compare_field("last_of_step", 8'(want.last_of_step), 8'(got.last_of_step));
    end
  endfunction

  always @(posedge clk) begin
    byte_fire <= text_bus.valid && text_bus.ready;
    if (!rst) begin
      if (text_bus.valid && text_bus.ready) begin
        bytes_taken++;
        lex_byte(text_bus.in_byte, text_bus.end_of_input);
      end
      if (token_bus.valid && token_bus.ready) check_token_beat();
    end
  end

  always @(negedge clk) begin
    text_item_t it;
    if (rst) begin
      text_bus.valid <= 1'b0;
    end else if (!text_bus.valid || byte_fire) begin
      if (pending_text.size() != 0 && $urandom_range(99) >= send_idle_pct &&
          !(pending_text[0].wait_empty && expected_beats.size() != 0)) begin
        it = pending_text.pop_front();
        text_bus.valid        <= 1'b1;
        text_bus.in_byte      <= it.text_byte;
        text_bus.end_of_input <= it.eoi;
      end else begin
        text_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    token_bus.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push_item(logic [7:0] b, logic eoi);
    text_item_t it;
    it.text_byte  = b;
    it.eoi        = eoi;
    it.wait_empty = hold_next;
    hold_next     = 1'b0;
    pending_text.push_back(it);
    bytes_loaded++;
    phase_items++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
  endtask

  task automatic push_separator();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) push_item(CH_SPACE, 1'b0);
    else if (pick == 4) push_item(CH_TAB, 1'b0);
    else if (pick == 5) push_item(CH_NEWLINE, 1'b0);
    else if (pick < 9) push_item(marks[$urandom_range(8)], 1'b0);
    else push_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic queue_random_string();
    logic [7:0] delim;
    logic [7:0] c;
    int         pick;
    delim = $urandom_range(1) ? CH_SQUOTE : CH_DQUOTE;
    push_item(delim, 1'b0);
    repeat ($urandom_range(8)) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        do c = 8'($urandom_range(255));
        while (c == CH_NEWLINE || c == delim || c == CH_BSLASH);
        push_item(c, 1'b0);
      end else begin
        push_item(CH_BSLASH, 1'b0);
        if (pick == 7) begin
          c = $urandom_range(1) ? CH_LOWER_N : CH_LOWER_T;
        end else if (pick == 8) begin
          c = $urandom_range(1) ? CH_BSLASH : delim;
        end else begin
          do c = 8'($urandom_range(255)); while (c == CH_NEWLINE);
        end
        push_item(c, 1'b0);
      end
    end
    pick = $urandom_range(19);
    if (pick < 17) push_item(delim, 1'b0);
    else if (pick < 19) push_item(CH_NEWLINE, 1'b0);
    else push_item(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic queue_random_token();
    int         pick;
    logic [7:0] c;
    if ($urandom_range(39) == 0) hold_next = 1'b1;
    pick = $urandom_range(99);
    if (pick < 15) begin
      push_item(marks[$urandom_range(8)], 1'b0);
    end else if (pick < 22) begin
      push_separator();
    end else if (pick < 42) begin
      do c = 8'($urandom_range(255));
      while (is_blank(c) || is_mark(c) || is_decimal(c) || c == CH_SQUOTE ||
             c == CH_DQUOTE);
      push_item(c, 1'b0);
      repeat ($urandom_range(5)) begin
        do c = 8'($urandom_range(255)); while (is_blank(c) || is_mark(c));
        push_item(c, 1'b0);
      end
      push_separator();
    end else if (pick < 57) begin
      repeat ($urandom_range(4) + 1) push_item(8'(CH_ZERO + $urandom_range(9)), 1'b0);
      push_separator();
    end else if (pick < 90) begin
      queue_random_string();
    end else begin
      c = 8'($urandom_range(255));
      push_item(c, 1'b0);
      if (c == CH_SQUOTE || c == CH_DQUOTE) push_item(CH_NEWLINE, 1'b0);
      else push_separator();
    end
  endtask

  task automatic wait_until_drained();
    while (bytes_taken != bytes_loaded || expected_beats.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned idle_plan [4];
    int unsigned stall_plan [4];
    idle_plan  = '{0, 82, 0, 32};
    stall_plan = '{0, 0, 82, 32};
    rst                    = 1'b1;
    text_bus.valid         = 1'b0;
    text_bus.in_byte       = 8'd0;
    text_bus.end_of_input  = 1'b0;
    token_bus.ready        = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    push_text("()");
    push_item(8'h00, 1'b0);
    push_item(8'hFF, 1'b0);
    push_text(".9;");
    push_text("\"\\n\\t\\\\\\q\\\"\"");
    push_text("'\\'\n");
    push_text("x");
    push_item(8'hA5, 1'b1);
    push_text("\"");
    push_item(8'h5A, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      wait_until_drained();
      send_idle_pct  = idle_plan[phase];
      recv_stall_pct = stall_plan[phase];
      phase_items    = 0;
      while (phase_items < PHASE_ITEMS) queue_random_token();
    end

    // A digit run running into a letter locks the lexer, so this comes last.
    wait_until_drained();
    push_text(" 7a");
    push_text("b(1 'q' ");
    push_item(8'h00, 1'b1);
    wait_until_drained();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
